// ===== sv/lts_pkg.sv =====
// Shared types, codes and helper functions for the link traffic statistics block.
package lts_pkg;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  // Command queue between the decoder and the execution unit
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Input operation codes
  typedef enum logic [3:0] {
    OP_ADD_TX_BYTES = 4'd0,
    OP_ADD_RX_BYTES = 4'd1,
    OP_SIZE_TX      = 4'd2,
    OP_SIZE_RX      = 4'd3,
    OP_ADD_TX_PKTS  = 4'd4,
    OP_ADD_RX_PKTS  = 4'd5,
    OP_RTT          = 4'd6,
    OP_TICK         = 4'd7,
    OP_CLEAR        = 4'd8
  } op_e;

  // Decoded command kinds
  typedef enum logic [3:0] {
    K_ADD_TX_BYTES = 4'd0,
    K_ADD_RX_BYTES = 4'd1,
    K_SIZE_TX      = 4'd2,
    K_SIZE_RX      = 4'd3,
    K_ADD_TX_PKTS  = 4'd4,
    K_ADD_RX_PKTS  = 4'd5,
    K_RTT          = 4'd6,
    K_TICK         = 4'd7,
    K_CLEAR        = 4'd8,
    K_NOP          = 4'd15
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] arg;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic dividing;
  } back_stat_t;

  // (a + b) >> 1 with a 33-bit sum
  function automatic logic [31:0] halve_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32:1];
  endfunction

  // Halving average; an empty average takes the sample as is
  function automatic logic [31:0] blend(input logic [31:0] avg, input logic [31:0] sample);
    return (avg == 32'd0) ? sample : halve_sum(sample, avg);
  endfunction

endpackage

// ===== sv/lts_front.sv =====
// Input stage: registers one beat and decodes it into a command for the queue.
module lts_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [3:0]     operation_i,
  input  logic [31:0]    amount_i,
  input  logic [31:0]    rtt_value_i,
  input  logic [31:0]    elapsed_time_i,
  input  lts_pkg::q_stat_t q_stat_i,
  output logic           q_push_o,
  output lts_pkg::cmd_t  q_cmd_o
);

  logic          valid_q, valid_d;
  lts_pkg::cmd_t cmd_q, cmd_d;
  logic          in_acc;

  assign in_stall_o = valid_q & q_stat_i.full;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign q_push_o   = valid_q & ~q_stat_i.full;
  assign q_cmd_o    = cmd_q;

  always_comb begin
    cmd_d.arg = amount_i;
    case (operation_i)
      lts_pkg::OP_ADD_TX_BYTES: cmd_d.kind = lts_pkg::K_ADD_TX_BYTES;
      lts_pkg::OP_ADD_RX_BYTES: cmd_d.kind = lts_pkg::K_ADD_RX_BYTES;
      lts_pkg::OP_SIZE_TX:      cmd_d.kind = lts_pkg::K_SIZE_TX;
      lts_pkg::OP_SIZE_RX:      cmd_d.kind = lts_pkg::K_SIZE_RX;
      lts_pkg::OP_ADD_TX_PKTS:  cmd_d.kind = lts_pkg::K_ADD_TX_PKTS;
      lts_pkg::OP_ADD_RX_PKTS:  cmd_d.kind = lts_pkg::K_ADD_RX_PKTS;
      lts_pkg::OP_RTT: begin
        cmd_d.kind = lts_pkg::K_RTT;
        cmd_d.arg  = rtt_value_i;
      end
      lts_pkg::OP_TICK: begin
        cmd_d.kind = lts_pkg::K_TICK;
        cmd_d.arg  = elapsed_time_i;
      end
      lts_pkg::OP_CLEAR: begin
        cmd_d.kind = lts_pkg::K_CLEAR;
        cmd_d.arg  = 32'd0;
      end
      default: begin
        cmd_d.kind = lts_pkg::K_NOP;
        cmd_d.arg  = 32'd0;
      end
    endcase
  end

  // Hold the beat while the queue is full
  assign valid_d = in_acc | (valid_q & q_stat_i.full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ===== sv/lts_queue.sv =====
// Small command FIFO between the decoder and the execution unit.
module lts_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lts_pkg::cmd_t    push_cmd_i,
  input  logic             pop_i,
  output lts_pkg::cmd_t    head_o,
  output lts_pkg::q_stat_t stat_o
);

  lts_pkg::cmd_t                 mem_q [lts_pkg::QUEUE_DEPTH];
  logic [lts_pkg::QPTR_W-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [lts_pkg::QCNT_W-1:0]    count_q, count_d;
  logic                          do_push, do_pop;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == lts_pkg::QCNT_W'(lts_pkg::QUEUE_DEPTH));
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign head_o       = mem_q[rptr_q];

  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== sv/lts_div.sv =====
// Radix-2 restoring divider for the send rate, quotient saturated at 32 bits.
module lts_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] numer_i,
  input  logic [31:0] denom_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  localparam int DW    = 32 + FRAC_BITS;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_q, quo_d;
  logic [31:0]      rem_q, rem_d;
  logic [31:0]      den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [32:0]      rem_sh, rem_sub;
  logic             fits;

  assign rem_sh  = {rem_q, quo_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = (rem_sh >= {1'b0, den_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      quo_d  = {numer_i, {FRAC_BITS{1'b0}}};
      rem_d  = '0;
      cnt_d  = CNT_W'(DW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so 32 bits hold it
      rem_d  = fits ? rem_sub[31:0] : rem_sh[31:0];
      quo_d  = {quo_q[DW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= denom_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = (|quo_q[DW-1:32]) ? lts_pkg::ALL_ONES : quo_q[31:0];

endmodule

// ===== sv/lts_back.sv =====
// Execution unit: applies queued commands to the statistics and drives the result register.
module lts_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lts_pkg::cmd_t       cmd_i,
  input  lts_pkg::q_stat_t    q_stat_i,
  output logic                q_pop_o,
  output lts_pkg::back_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [31:0]         echo_value_o,
  output logic [31:0]         total_bytes_sent_o,
  output logic [31:0]         total_bytes_recv_o,
  output logic [31:0]         total_packets_sent_o,
  output logic [31:0]         total_packets_recv_o,
  output logic [31:0]         send_rate_o,
  output logic [31:0]         mean_rtt_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_e;

  state_e      state_q, state_d;

  logic [31:0] bst_q, bst_d, brt_q, brt_d;
  logic [31:0] pst_q, pst_d, prt_q, prt_d;
  logic [31:0] blt_q, blt_d, abd_q, abd_d, rate_q, rate_d;
  logic [31:0] lsz_q [2];
  logic [31:0] lsz_d [2];
  logic [31:0] ssz_q [2];
  logic [31:0] ssz_d [2];
  logic [31:0] msz_q [2];
  logic [31:0] msz_d [2];
  logic [31:0] lrtt_q, lrtt_d, srtt_q, srtt_d, artt_q, artt_d;

  logic        out_valid_q, out_valid_d;
  logic        out_free, out_load;
  logic [31:0] echo;
  logic        dir;
  logic [31:0] delta;
  logic        div_start, div_done;
  logic [31:0] div_quot;

  assign out_free = ~out_valid_q | ~out_stall_i;
  assign dir      = (cmd_i.kind == lts_pkg::K_SIZE_RX);
  assign delta    = bst_q - blt_q;
  assign stat_o.dividing = (state_q == ST_DIV);

  always_comb begin
    if (cmd_i.kind inside {lts_pkg::K_ADD_TX_BYTES, lts_pkg::K_ADD_RX_BYTES,
                           lts_pkg::K_SIZE_TX, lts_pkg::K_SIZE_RX,
                           lts_pkg::K_ADD_TX_PKTS, lts_pkg::K_ADD_RX_PKTS}) begin
      echo = cmd_i.arg;
    end else if (cmd_i.kind == lts_pkg::K_CLEAR) begin
      echo = lts_pkg::ALL_ONES;
    end else begin
      echo = 32'd0;
    end
  end

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    bst_d = bst_q;  brt_d = brt_q;  pst_d = pst_q;  prt_d = prt_q;
    blt_d = blt_q;  abd_d = abd_q;  rate_d = rate_q;
    lsz_d = lsz_q;  ssz_d = ssz_q;  msz_d = msz_q;
    lrtt_d = lrtt_q;  srtt_d = srtt_q;  artt_d = artt_q;

    case (state_q)
      ST_IDLE: begin
        if (!q_stat_i.empty && out_free) begin
          q_pop_o  = 1'b1;
          out_load = 1'b1;
          case (cmd_i.kind)
            lts_pkg::K_ADD_TX_BYTES: bst_d = bst_q + cmd_i.arg;
            lts_pkg::K_ADD_RX_BYTES: brt_d = brt_q + cmd_i.arg;
            lts_pkg::K_ADD_TX_PKTS:  pst_d = pst_q + cmd_i.arg;
            lts_pkg::K_ADD_RX_PKTS:  prt_d = prt_q + cmd_i.arg;
            lts_pkg::K_SIZE_TX, lts_pkg::K_SIZE_RX: begin
              if (lsz_q[dir] <= cmd_i.arg) lsz_d[dir] = cmd_i.arg;
              if (cmd_i.arg <= ssz_q[dir]) ssz_d[dir] = cmd_i.arg;
              msz_d[dir] = lts_pkg::blend(msz_q[dir], cmd_i.arg);
            end
            lts_pkg::K_RTT: begin
              if (lrtt_q <= cmd_i.arg) lrtt_d = cmd_i.arg;
              if (cmd_i.arg <= srtt_q) srtt_d = cmd_i.arg;
              artt_d = lts_pkg::blend(artt_q, cmd_i.arg);
            end
            lts_pkg::K_TICK: begin
              if (cmd_i.arg != 32'd0) begin
                blt_d     = bst_q;
                abd_d     = lts_pkg::halve_sum(delta, abd_q);
                div_start = 1'b1;
                out_load  = 1'b0;
                state_d   = ST_DIV;
              end
            end
            lts_pkg::K_CLEAR: begin
              bst_d = '0;  brt_d = '0;  pst_d = '0;  prt_d = '0;
              blt_d = '0;  abd_d = '0;  rate_d = '0;
              lsz_d[0] = '0;  lsz_d[1] = '0;
              ssz_d[0] = lts_pkg::ALL_ONES;  ssz_d[1] = lts_pkg::ALL_ONES;
              msz_d[0] = '0;  msz_d[1] = '0;
              lrtt_d = '0;  srtt_d = lts_pkg::ALL_ONES;  artt_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        // the divider holds its quotient until the result slot frees up
        if (div_done && out_free) begin
          rate_d   = div_quot;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  lts_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (abd_d),
    .denom_i (cmd_i.arg),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      bst_q <= '0;  brt_q <= '0;  pst_q <= '0;  prt_q <= '0;
      blt_q <= '0;  abd_q <= '0;  rate_q <= '0;
      lsz_q[0] <= '0;  lsz_q[1] <= '0;
      ssz_q[0] <= lts_pkg::ALL_ONES;  ssz_q[1] <= lts_pkg::ALL_ONES;
      msz_q[0] <= '0;  msz_q[1] <= '0;
      lrtt_q <= '0;  srtt_q <= lts_pkg::ALL_ONES;  artt_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bst_q <= bst_d;  brt_q <= brt_d;  pst_q <= pst_d;  prt_q <= prt_d;
      blt_q <= blt_d;  abd_q <= abd_d;  rate_q <= rate_d;
      lsz_q <= lsz_d;  ssz_q <= ssz_d;  msz_q <= msz_d;
      lrtt_q <= lrtt_d;  srtt_q <= srtt_d;  artt_q <= artt_d;
    end
  end

  // Result register takes the totals as they stand after the event
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      echo_value_o         <= (state_q == ST_DIV) ? 32'd0 : echo;
      total_bytes_sent_o   <= bst_d;
      total_bytes_recv_o   <= brt_d;
      total_packets_sent_o <= pst_d;
      total_packets_recv_o <= prt_d;
      send_rate_o          <= rate_d;
      mean_rtt_o           <= artt_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/link_traffic_statistics.sv =====
// Top level of the link traffic statistics block.
// Each input beat is one statistics event and yields exactly one result beat, in order.
// Events pass an input register and a four-entry command queue, then the execution
// unit applies one event per cycle while the result register is not stalled, so byte,
// packet, size, round-trip and clear events sustain one beat per cycle. A rate tick
// with nonzero elapsed time runs a one-bit-per-cycle divider over 32 + FRAC_BITS
// quotient bits and occupies the execution unit until the quotient is taken into the
// result register; the queue keeps taking input beats meanwhile until it fills.
module link_traffic_statistics #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  operation_i,
  input  logic [31:0] amount_i,
  input  logic [31:0] rtt_value_i,
  input  logic [31:0] elapsed_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] echo_value_o,
  output logic [31:0] total_bytes_sent_o,
  output logic [31:0] total_bytes_recv_o,
  output logic [31:0] total_packets_sent_o,
  output logic [31:0] total_packets_recv_o,
  output logic [31:0] send_rate_o,
  output logic [31:0] mean_rtt_o
);

  lts_pkg::q_stat_t    q_stat;
  lts_pkg::cmd_t       push_cmd, head_cmd;
  lts_pkg::back_stat_t back_stat;
  logic                q_push, q_pop;

  lts_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .amount_i       (amount_i),
    .rtt_value_i    (rtt_value_i),
    .elapsed_time_i (elapsed_time_i),
    .q_stat_i       (q_stat),
    .q_push_o       (q_push),
    .q_cmd_o        (push_cmd)
  );

  lts_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .stat_o     (q_stat)
  );

  lts_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (head_cmd),
    .q_stat_i             (q_stat),
    .q_pop_o              (q_pop),
    .stat_o               (back_stat),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .echo_value_o         (echo_value_o),
    .total_bytes_sent_o   (total_bytes_sent_o),
    .total_bytes_recv_o   (total_bytes_recv_o),
    .total_packets_sent_o (total_packets_sent_o),
    .total_packets_recv_o (total_packets_recv_o),
    .send_rate_o          (send_rate_o),
    .mean_rtt_o           (mean_rtt_o)
  );

  // no command leaves the queue while a rate division is in flight
  a_no_pop_while_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.dividing |-> !q_pop)
    else $error("command popped during rate division");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty command queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("push into full command queue");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(total_bytes_sent_o))
    else $error("stalled result beat changed");

endmodule
